### rtl/core/tcfm_pkg.sv
// Shared types, constants and defaults for the terminal command frame matcher.
package tcfm_pkg;

	// Default sizes
	localparam int BUFFER_BYTES_DEF      = 64;
	localparam int MAX_COMMAND_BYTES_DEF = 8;

	// Configuration port geometry: 64-bit registers at 8-byte spacing
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 4;
	localparam int TEXT_W    = 64;
	localparam int CMD_LEN_W = 4;

	// Register select codes (paddr bit 3)
	localparam logic REG_TEXT   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	// Frame bytes
	localparam logic [7:0] BYTE_START    = 8'hFF;
	localparam logic [7:0] BYTE_MODULE   = 8'h0E;
	localparam logic [7:0] BYTE_FUNCTION = 8'h01;
	localparam logic [7:0] BYTE_ARGS     = 8'h01;
	localparam logic [7:0] BYTE_END      = 8'h00;

	// Frame phase, one-hot
	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_MODULE   = 7'b0000010,
		PH_FUNCTION = 7'b0000100,
		PH_ARGS     = 7'b0001000,
		PH_LENGTH   = 7'b0010000,
		PH_PAYLOAD  = 7'b0100000,
		PH_TAIL     = 7'b1000000
	} phase_t;

	// Configuration as seen by the parser
	typedef struct packed {
		logic [TEXT_W-1:0]    text;
		logic [CMD_LEN_W-1:0] cmd_len;
	} cfg_t;

endpackage

### rtl/core/terminal_command_frame_matcher_top.sv
// A word captured in the input register passes through the parser into the result register.
// Throughput: one word per cycle; the input register advances whenever the
// result register is empty or being taken in the same cycle.
// The frame state is one small update per byte in a single stage.
// Reset (arst_n low, asynchronous) empties both stages, returns the parser to
// idle and clears the command registers.
module terminal_command_frame_matcher_top #(
	parameter int BUFFER_BYTES      = tcfm_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_COMMAND_BYTES = tcfm_pkg::MAX_COMMAND_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcfm_pkg::ADDR_W-1:0] paddr,
	input  logic [tcfm_pkg::DATA_W-1:0] pwdata,
	output logic [tcfm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	// received bytes
	input  logic                        rx_valid,
	output logic                        rx_stall,
	input  logic [7:0]                  rx_byte,
	// results
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic                        frame_done,
	output logic                        command_matched
);

	tcfm_pkg::cfg_t cfg;
	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           advance;
	logic           res_valid_q;
	logic           done_q;
	logic           matched_q;
	logic           done_c;
	logic           matched_c;

	tcfm_regs #(
		.MAX_COMMAND_BYTES(MAX_COMMAND_BYTES)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	tcfm_parse #(
		.BUFFER_BYTES     (BUFFER_BYTES),
		.MAX_COMMAND_BYTES(MAX_COMMAND_BYTES)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.rx_byte        (byte_s1),
		.cfg            (cfg),
		.frame_done     (done_c),
		.command_matched(matched_c)
	);

	// Stage handshake
	assign advance  = valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && res_valid_q && res_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q    <= done_c;
			matched_q <= matched_c;
		end
	end

	assign res_valid       = res_valid_q;
	assign frame_done      = done_q;
	assign command_matched = matched_q;

`ifndef NO_ASSERTIONS
	// a match is only ever reported on a closing byte
	a_match_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && matched_q |-> done_q)
		else $error("match reported without frame close");

	// input only stalls when both stages are full and the output is held
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled with room in the pipeline");

	// a word moving out of the input register lands in the result register
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("advanced word lost");

	// a held result is not overwritten by a new word
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_stall |-> !advance)
		else $error("result overwritten while stalled");
`endif

endmodule

### rtl/core/tcfm_regs.sv
// Configuration registers with APB-style access and command length derivation.
module tcfm_regs #(
	parameter int MAX_COMMAND_BYTES = tcfm_pkg::MAX_COMMAND_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcfm_pkg::ADDR_W-1:0] paddr,
	input  logic [tcfm_pkg::DATA_W-1:0] pwdata,
	output logic [tcfm_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output tcfm_pkg::cfg_t              cfg
);

	localparam logic [tcfm_pkg::CMD_LEN_W-1:0] MaxLen =
		tcfm_pkg::CMD_LEN_W'(MAX_COMMAND_BYTES);

	logic [tcfm_pkg::TEXT_W-1:0]    text_q;
	logic [tcfm_pkg::CMD_LEN_W-1:0] length_q;
	logic [tcfm_pkg::CMD_LEN_W-1:0] lim;
	logic [tcfm_pkg::CMD_LEN_W-1:0] cmd_len;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q   <= '0;
			length_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				tcfm_pkg::REG_TEXT:   text_q   <= pwdata[tcfm_pkg::TEXT_W-1:0];
				tcfm_pkg::REG_LENGTH: length_q <= pwdata[tcfm_pkg::CMD_LEN_W-1:0];
				default:              text_q   <= text_q;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[3])
			tcfm_pkg::REG_LENGTH:
				prdata = tcfm_pkg::DATA_W'(length_q);
			default:
				prdata = tcfm_pkg::DATA_W'(text_q);
		endcase
	end

	// Effective command length: clamp, then cut at the first zero byte
	always_comb begin
		lim = (length_q > MaxLen) ? MaxLen : length_q;
		cmd_len = lim;
		for (int i = 7; i >= 0; i--) begin
			if (tcfm_pkg::CMD_LEN_W'(i) < lim && text_q[8*i +: 8] == tcfm_pkg::BYTE_END) begin
				cmd_len = tcfm_pkg::CMD_LEN_W'(i);
			end
		end
	end

	assign cfg.text    = text_q;
	assign cfg.cmd_len = cmd_len;

endmodule

### rtl/core/tcfm_parse.sv
// Frame state tracker with on-the-fly payload text compare.
module tcfm_parse #(
	parameter int BUFFER_BYTES      = tcfm_pkg::BUFFER_BYTES_DEF,
	parameter int MAX_COMMAND_BYTES = tcfm_pkg::MAX_COMMAND_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     rx_byte,
	input  tcfm_pkg::cfg_t cfg,
	output logic           frame_done,
	output logic           command_matched
);

	localparam int LW  = (BUFFER_BYTES > 2) ? $clog2(BUFFER_BYTES) : 1;
	localparam int TCW = $clog2(MAX_COMMAND_BYTES + 1);

	tcfm_pkg::phase_t phase_q, phase_nx;
	logic [LW-1:0]    plen_q, plen_nx;
	logic [LW-1:0]    taken_q, taken_nx;
	logic             ended_q, ended_nx;
	logic             mism_q, mism_nx;
	logic [TCW-1:0]   tcount_q, tcount_nx;
	logic [2:0]       cmd_idx;
	logic [7:0]       cmd_byte;
	logic             len_ok;

	// Command byte at the current text position
	assign cmd_idx  = 3'(tcount_q);
	assign cmd_byte = cfg.text[{cmd_idx, 3'b000} +: 8];
	assign len_ok   = {1'b0, rx_byte} < 9'(BUFFER_BYTES);

	// Next state and result for the current byte
	always_comb begin
		phase_nx        = phase_q;
		plen_nx         = plen_q;
		taken_nx        = taken_q;
		ended_nx        = ended_q;
		mism_nx         = mism_q;
		tcount_nx       = tcount_q;
		frame_done      = 1'b0;
		command_matched = 1'b0;
		unique case (phase_q)
			tcfm_pkg::PH_MODULE: begin
				phase_nx = (rx_byte == tcfm_pkg::BYTE_MODULE) ?
					tcfm_pkg::PH_FUNCTION : tcfm_pkg::PH_IDLE;
			end
			tcfm_pkg::PH_FUNCTION: begin
				phase_nx = (rx_byte == tcfm_pkg::BYTE_FUNCTION) ?
					tcfm_pkg::PH_ARGS : tcfm_pkg::PH_IDLE;
			end
			tcfm_pkg::PH_ARGS: begin
				phase_nx = (rx_byte == tcfm_pkg::BYTE_ARGS) ?
					tcfm_pkg::PH_LENGTH : tcfm_pkg::PH_IDLE;
			end
			tcfm_pkg::PH_LENGTH: begin
				if (len_ok) begin
					plen_nx   = rx_byte[LW-1:0];
					taken_nx  = '0;
					ended_nx  = 1'b0;
					mism_nx   = 1'b0;
					tcount_nx = '0;
					phase_nx  = tcfm_pkg::PH_PAYLOAD;
				end else begin
					phase_nx = tcfm_pkg::PH_IDLE;
				end
			end
			tcfm_pkg::PH_PAYLOAD: begin
				// zero length still eats one byte, with empty text
				if (plen_q != '0 && !ended_q) begin
					if (rx_byte == tcfm_pkg::BYTE_END) begin
						ended_nx = 1'b1;
					end else if (tcfm_pkg::CMD_LEN_W'(tcount_q) >= cfg.cmd_len) begin
						mism_nx = 1'b1;
					end else begin
						if (cmd_byte != rx_byte) begin
							mism_nx = 1'b1;
						end
						tcount_nx = tcount_q + 1'b1;
					end
				end
				taken_nx = taken_q + 1'b1;
				if (taken_nx >= plen_q) begin
					phase_nx = tcfm_pkg::PH_TAIL;
				end
			end
			tcfm_pkg::PH_TAIL: begin
				if (rx_byte == tcfm_pkg::BYTE_END) begin
					frame_done      = 1'b1;
					command_matched = !mism_q &&
						(tcfm_pkg::CMD_LEN_W'(tcount_q) == cfg.cmd_len);
					phase_nx        = tcfm_pkg::PH_IDLE;
				end
			end
			default: begin
				// idle and any stray code hunt for the start byte
				phase_nx = (rx_byte == tcfm_pkg::BYTE_START) ?
					tcfm_pkg::PH_MODULE : tcfm_pkg::PH_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tcfm_pkg::PH_IDLE;
			plen_q   <= '0;
			taken_q  <= '0;
			ended_q  <= 1'b0;
			mism_q   <= 1'b0;
			tcount_q <= '0;
		end else if (step) begin
			phase_q  <= phase_nx;
			plen_q   <= plen_nx;
			taken_q  <= taken_nx;
			ended_q  <= ended_nx;
			mism_q   <= mism_nx;
			tcount_q <= tcount_nx;
		end
	end

endmodule
